### sv/opwc_pkg.sv
package opwc_pkg;

   localparam int unsigned WidthBitsDefault = 24;

   localparam int unsigned MbdBits   = 23;
   localparam int unsigned TickBits  = 25;
   localparam int unsigned CountBits = 17;
   localparam int unsigned PwBits    = 24;
   localparam int unsigned IndexBits = 2;
   localparam int unsigned DataBits  = 32;

   localparam logic [TickBits-1:0]  TickMax  = '1;
   localparam logic [CountBits-1:0] CountMax = '1;

   localparam logic [MbdBits-1:0]   MbdReset = MbdBits'(7000);
   localparam logic [TickBits-1:0]  FwlReset = TickBits'(20000000);
   localparam logic [CountBits-1:0] CapReset = CountBits'(80000);

   // register indexes
   localparam logic [IndexBits-1:0] RegMaxBitDuration = 2'd0;
   localparam logic [IndexBits-1:0] RegFirstWaitLimit = 2'd1;
   localparam logic [IndexBits-1:0] RegCaptureLimit   = 2'd2;

   // op codes
   localparam logic OpTick = 1'b0;
   localparam logic OpArm  = 1'b1;

   typedef struct packed {
      logic [MbdBits-1:0]   max_bit_duration;
      logic [TickBits-1:0]  first_wait_limit;
      logic [CountBits-1:0] capture_limit;
   } cfg_type;

   typedef struct packed {
      logic                 has_result;
      logic                 pulse_valid;
      logic [PwBits-1:0]    pulse_width;
      logic [CountBits-1:0] captured_count;
      logic                 capture_done;
      logic                 buffer_full;
   } result_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_WAIT = 3'b010,
      PH_MEAS = 3'b100
   } phase_type;

endpackage

### sv/opwc_csr.sv
module opwc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [opwc_pkg::IndexBits-1:0]    csr_index,
   input  logic [opwc_pkg::DataBits-1:0]     csr_data,
   output opwc_pkg::cfg_type                 cfg
);

   opwc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            opwc_pkg::RegMaxBitDuration:
               cfg_in.max_bit_duration = csr_data[opwc_pkg::MbdBits-1:0];
            opwc_pkg::RegFirstWaitLimit:
               cfg_in.first_wait_limit = csr_data[opwc_pkg::TickBits-1:0];
            opwc_pkg::RegCaptureLimit:
               cfg_in.capture_limit = csr_data[opwc_pkg::CountBits-1:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_bit_duration <= opwc_pkg::MbdReset;
         cfg_ff.first_wait_limit <= opwc_pkg::FwlReset;
         cfg_ff.capture_limit    <= opwc_pkg::CapReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/opwc_core.sv
module opwc_core #(
   parameter int unsigned WIDTH_BITS = opwc_pkg::WidthBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 op,
   input  logic                 sample,
   input  opwc_pkg::cfg_type    cfg,
   output opwc_pkg::result_type res
);

   localparam int unsigned TB = opwc_pkg::TickBits;
   localparam int unsigned CB = opwc_pkg::CountBits;
   localparam int unsigned PB = opwc_pkg::PwBits;
   localparam logic [32:0] WidthMax = 33'((64'd1 << WIDTH_BITS) - 64'd1);

   opwc_pkg::phase_type phase_ff, phase_in;
   logic          level_ff, level_in;
   logic [TB-1:0] since_ff, since_in;
   logic [TB-1:0] wait_ff, wait_in;
   logic [CB-1:0] count_ff, count_in;

   logic [TB-1:0] limit2;
   logic [TB-1:0] since_inc;
   logic [CB-1:0] count_inc;
   logic [PB-1:0] width_sat;
   logic          start;
   logic          fall;
   logic          rise;
   logic          full;

   assign limit2    = {1'b0, cfg.max_bit_duration, 1'b0};
   assign since_inc = (since_ff == opwc_pkg::TickMax) ? since_ff : since_ff + TB'(1);
   assign count_inc = (count_ff == opwc_pkg::CountMax) ? count_ff : count_ff + CB'(1);
   assign width_sat = ({8'd0, since_inc} > WidthMax) ? WidthMax[PB-1:0] : since_inc[PB-1:0];
   assign start     = sample || (wait_ff >= cfg.first_wait_limit);
   assign fall      = !sample && level_ff;
   assign rise      = sample && !level_ff;
   assign full      = fall && (count_inc == cfg.capture_limit);

   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      since_in = since_ff;
      wait_in  = wait_ff;
      count_in = count_ff;
      res      = '0;
      res.captured_count = count_ff;
      if (op == opwc_pkg::OpArm) begin
         phase_in = opwc_pkg::PH_WAIT;
         level_in = 1'b0;
         since_in = '0;
         wait_in  = '0;
         count_in = '0;
      end else begin
         unique case (phase_ff)
            opwc_pkg::PH_WAIT: begin
               if (start) begin
                  phase_in = opwc_pkg::PH_MEAS;
                  level_in = 1'b1;
                  since_in = '0;
                  if (limit2 == '0) begin
                     // zero timeout: session ends before any pulse
                     phase_in         = opwc_pkg::PH_IDLE;
                     res.has_result   = 1'b1;
                     res.capture_done = 1'b1;
                  end
               end else if (wait_ff != opwc_pkg::TickMax) begin
                  wait_in = wait_ff + TB'(1);
               end
            end
            opwc_pkg::PH_MEAS: begin
               since_in = since_inc;
               if (fall) begin
                  level_in           = 1'b0;
                  count_in           = count_inc;
                  res.pulse_valid    = 1'b1;
                  res.pulse_width    = width_sat;
                  res.captured_count = count_inc;
                  res.buffer_full    = full;
               end else if (rise) begin
                  since_in = '0;
                  level_in = 1'b1;
               end
               res.capture_done = full || (since_in >= limit2);
               res.has_result   = fall || res.capture_done;
               if (res.capture_done) begin
                  phase_in = opwc_pkg::PH_IDLE;
               end
            end
            default: ; // idle: tick ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= opwc_pkg::PH_IDLE;
         level_ff <= 1'b0;
         since_ff <= '0;
         wait_ff  <= '0;
         count_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         since_ff <= since_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/opwc_out_reg.sv
module opwc_out_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  opwc_pkg::result_type                res,
   output logic                                space,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pulse_valid,
   output logic [opwc_pkg::PwBits-1:0]         rsp_pulse_width,
   output logic [opwc_pkg::CountBits-1:0]      rsp_captured_count,
   output logic                                rsp_capture_done,
   output logic                                rsp_buffer_full
);

   logic                 valid_ff, valid_in;
   opwc_pkg::result_type data_ff;

   // free now, or freed by the transfer in this cycle
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = (load && res.has_result) || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res.has_result) begin
         data_ff <= res;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_pulse_valid    = data_ff.pulse_valid;
   assign rsp_pulse_width    = data_ff.pulse_width;
   assign rsp_captured_count = data_ff.captured_count;
   assign rsp_capture_done   = data_ff.capture_done;
   assign rsp_buffer_full    = data_ff.buffer_full;

endmodule

### sv/optical_pulse_width_capture.sv
// Pulse width capture for a light-sensing pin. Each req_ transfer is one
// microsecond sample tick (op=0, level in req_sample) or an arm command
// (op=1), which restarts a session at once and clears the count. After arming
// the block waits for the first high sample, or first_wait_limit ticks, then
// times every pulse from its rise; each fall returns one rsp_ transfer with the
// width (saturated to WIDTH_BITS bits) and the running count. A session ends
// after 2*max_bit_duration ticks without a rise, or when the count reaches
// capture_limit; that result has capture_done set, with buffer_full for the
// limit case. Rate: one item per clock unless the output stalls. All work
// for an item is done in the cycle it is accepted and lands in a single
// output register; req_ready drops only while that register holds a result
// and rsp_ready is low; rsp_valid rises in the cycle after a result item is
// accepted. csr_ writes are always accepted and take effect for the next tick.
module optical_pulse_width_capture #(
   parameter int unsigned WIDTH_BITS = opwc_pkg::WidthBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample / arm items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic                                req_sample,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pulse_valid,
   output logic [opwc_pkg::PwBits-1:0]         rsp_pulse_width,
   output logic [opwc_pkg::CountBits-1:0]      rsp_captured_count,
   output logic                                rsp_capture_done,
   output logic                                rsp_buffer_full,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [opwc_pkg::IndexBits-1:0]      csr_index,
   input  logic [opwc_pkg::DataBits-1:0]       csr_data
);

   opwc_pkg::cfg_type    cfg;
   opwc_pkg::result_type res;
   logic                 space;
   logic                 fire;

   // an item transfers whenever the output register can take its result
   assign req_ready = space;
   assign fire      = req_valid && req_ready;

   opwc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // session state and per-tick decision
   opwc_core #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .op     (req_op),
      .sample (req_sample),
      .cfg    (cfg),
      .res    (res)
   );

   // result register, loaded only by items that produce a result
   opwc_out_reg u_out (
      .clock              (clock),
      .reset              (reset),
      .load               (fire),
      .res                (res),
      .space              (space),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pulse_valid    (rsp_pulse_valid),
      .rsp_pulse_width    (rsp_pulse_width),
      .rsp_captured_count (rsp_captured_count),
      .rsp_capture_done   (rsp_capture_done),
      .rsp_buffer_full    (rsp_buffer_full)
   );

endmodule

### sv/opwc_checker.sv
module opwc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_pulse_valid,
   input logic [opwc_pkg::PwBits-1:0]         rsp_pulse_width,
   input logic [opwc_pkg::CountBits-1:0]      rsp_captured_count,
   input logic                                rsp_capture_done,
   input logic                                rsp_buffer_full
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped without transfer");

   a_no_pulse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pulse_valid |-> rsp_pulse_width == '0)
      else $error("width nonzero on result without pulse");

   a_full_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_buffer_full |-> rsp_capture_done && rsp_pulse_valid)
      else $error("buffer_full without done pulse");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_capture_done |-> rsp_pulse_valid)
      else $error("result with neither pulse nor done");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pulse_valid |-> rsp_captured_count != '0)
      else $error("pulse result with zero count");

endmodule

bind optical_pulse_width_capture opwc_checker u_opwc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_pulse_valid    (rsp_pulse_valid),
   .rsp_pulse_width    (rsp_pulse_width),
   .rsp_captured_count (rsp_captured_count),
   .rsp_capture_done   (rsp_capture_done),
   .rsp_buffer_full    (rsp_buffer_full)
);
